// ===== rtl/mse_pkg.sv =====
package mse_pkg;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SW      = 6'h2B;

  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLTU = 6'h2B;

  localparam logic [4:0] LINK_REG = 5'd31;

  typedef enum logic [2:0] {
    MEM_NONE = 3'd0,
    MEM_LW   = 3'd1,
    MEM_LB   = 3'd2,
    MEM_SW   = 3'd3,
    MEM_SB   = 3'd4
  } mem_kind_t;

  typedef struct packed {
    logic [31:0] result;
    logic        write_enable;
    logic [4:0]  dest_reg;
    logic        redirect;
    logic [31:0] target;
    mem_kind_t   mem_kind;
    logic [31:0] mem_address;
    logic        unsupported;
  } exec_res_t;

endpackage

// ===== rtl/mse_exec.sv =====
module mse_exec (
  input  logic [31:0]       instruction,
  input  logic [31:0]       rs_value,
  input  logic [31:0]       rt_value,
  input  logic [31:0]       pc,
  output mse_pkg::exec_res_t res
);
  import mse_pkg::*;

  logic [5:0]  op;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [5:0]  fn;
  logic [31:0] zimm;
  logic [31:0] simm;
  logic [31:0] next_pc;
  logic [31:0] branch_dest;
  logic [31:0] ea;
  exec_res_t   r;

  assign op          = instruction[31:26];
  assign rt          = instruction[20:16];
  assign rd          = instruction[15:11];
  assign sh          = instruction[10:6];
  assign fn          = instruction[5:0];
  assign zimm        = {16'h0000, instruction[15:0]};
  assign simm        = {{16{instruction[15]}}, instruction[15:0]};
  assign next_pc     = pc + 32'd4;
  assign branch_dest = next_pc + {simm[29:0], 2'b00};
  assign ea          = rs_value + simm;

  always_comb begin
    r = '0;
    r.mem_kind = MEM_NONE;
    case (op)
      OP_SPECIAL: begin
        r.write_enable = 1'b1;
        r.dest_reg     = rd;
        case (fn)
          FN_ADDU: r.result = rs_value + rt_value;
          FN_SUBU: r.result = rs_value - rt_value;
          FN_AND:  r.result = rs_value & rt_value;
          FN_OR:   r.result = rs_value | rt_value;
          FN_NOR:  r.result = ~(rs_value | rt_value);
          FN_SLTU: r.result = {31'd0, rs_value < rt_value};
          FN_SLL:  r.result = rt_value << sh;
          FN_SRL:  r.result = rt_value >> sh;
          FN_JR: begin
            r.write_enable = 1'b0;
            r.dest_reg     = '0;
            r.redirect     = 1'b1;
            r.target       = rs_value;
          end
          default: r.unsupported = 1'b1;
        endcase
      end
      OP_J, OP_JAL: begin
        r.redirect = 1'b1;
        r.target   = {next_pc[31:28], instruction[25:0], 2'b00};
        if (op == OP_JAL) begin
          r.write_enable = 1'b1;
          r.dest_reg     = LINK_REG;
          r.result       = next_pc;
        end
      end
      OP_ADDIU: begin
        r.write_enable = 1'b1;
        r.dest_reg     = rt;
        r.result       = ea;
      end
      OP_ANDI: begin
        r.write_enable = 1'b1;
        r.dest_reg     = rt;
        r.result       = rs_value & zimm;
      end
      OP_ORI: begin
        r.write_enable = 1'b1;
        r.dest_reg     = rt;
        r.result       = rs_value | zimm;
      end
      OP_SLTIU: begin
        r.write_enable = 1'b1;
        r.dest_reg     = rt;
        r.result       = {31'd0, rs_value < simm};
      end
      OP_LUI: begin
        r.write_enable = 1'b1;
        r.dest_reg     = rt;
        r.result       = {instruction[15:0], 16'h0000};
      end
      OP_BEQ: begin
        if (rs_value == rt_value) begin
          r.redirect = 1'b1;
          r.target   = branch_dest;
        end
      end
      OP_BNE: begin
        if (rs_value != rt_value) begin
          r.redirect = 1'b1;
          r.target   = branch_dest;
        end
      end
      OP_LW, OP_LB: begin
        r.mem_kind     = (op == OP_LW) ? MEM_LW : MEM_LB;
        r.mem_address  = ea;
        r.result       = ea;
        r.write_enable = 1'b1;
        r.dest_reg     = rt;
      end
      OP_SW, OP_SB: begin
        r.mem_kind    = (op == OP_SW) ? MEM_SW : MEM_SB;
        r.mem_address = ea;
        r.result      = ea;
      end
      default: r.unsupported = 1'b1;
    endcase
    if (r.unsupported) begin
      r = '0;
      r.mem_kind    = MEM_NONE;
      r.unsupported = 1'b1;
    end
  end

  assign res = r;

endmodule

// ===== rtl/mips_subset_execute_unit.sv =====
// Integer execute stage for a MIPS32 instruction subset.
// Input: pulse start with in_instruction, in_rs_value, in_rt_value and in_pc;
//   a transfer happens on any rising edge with start high and busy low.
//   busy is always low, so one instruction may be sent every cycle.
// Output: out_valid is high for exactly one cycle per instruction, with
//   the result fields alongside; the receiver cannot stall, so every
//   result must be taken in that cycle.
// Path from the input transfer to out_valid: input register, decode/ALU
//   logic, result register.
// Throughput: 1 instruction per cycle, set by the combinational ALU path between the registers.
// Unsupported opcodes or functs give out_unsupported with every other field
//   zero; unused fields are zero, but loads and stores put the address on out_result.
// Reset (rst_n low, synchronous) drops any instruction in flight and
//   holds out_valid low.
module mips_subset_execute_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_instruction,
  input  logic [31:0] in_rs_value,
  input  logic [31:0] in_rt_value,
  input  logic [31:0] in_pc,
  output logic        out_valid,
  output logic [31:0] out_result,
  output logic        out_write_enable,
  output logic [4:0]  out_dest_reg,
  output logic        out_redirect,
  output logic [31:0] out_target,
  output logic [2:0]  out_mem_kind,
  output logic [31:0] out_mem_address,
  output logic        out_unsupported
);
  import mse_pkg::*;

  logic        in_valid_r;
  logic        in_valid_nxt;
  logic [31:0] instr_r;
  logic [31:0] rs_r;
  logic [31:0] rt_r;
  logic [31:0] pc_r;
  logic        out_valid_r;
  exec_res_t   res_r;
  exec_res_t   res_nxt;
  logic        take;

  assign busy         = 1'b0;
  assign take         = start && !busy;
  assign in_valid_nxt = take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      instr_r <= in_instruction;
      rs_r    <= in_rs_value;
      rt_r    <= in_rt_value;
      pc_r    <= in_pc;
    end
    if (in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  mse_exec u_exec (
    .instruction (instr_r),
    .rs_value    (rs_r),
    .rt_value    (rt_r),
    .pc          (pc_r),
    .res         (res_nxt)
  );

  assign out_valid        = out_valid_r;
  assign out_result       = res_r.result;
  assign out_write_enable = res_r.write_enable;
  assign out_dest_reg     = res_r.dest_reg;
  assign out_redirect     = res_r.redirect;
  assign out_target       = res_r.target;
  assign out_mem_kind     = res_r.mem_kind;
  assign out_mem_address  = res_r.mem_address;
  assign out_unsupported  = res_r.unsupported;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("transfer did not produce a result two cycles later");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_valid_r))
    else $error("result strobe without an instruction in flight");

  a_bad_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_unsupported) |->
      (out_result == 32'd0 && !out_write_enable && !out_redirect &&
       out_mem_kind == MEM_NONE && out_mem_address == 32'd0))
    else $error("unsupported instruction left fields set");

  a_dest_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_write_enable) |-> out_dest_reg == 5'd0)
    else $error("destination set without write enable");

  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_mem_kind == MEM_NONE) |-> out_mem_address == 32'd0)
    else $error("memory address set without a memory access");
`endif

endmodule

// ===== tb/sv/tb_mips_subset_execute_unit.sv =====
`timescale 1ns / 1ps

module tb_mips_subset_execute_unit;
  import mse_pkg::*;

  localparam logic [5:0] BAD_OP = 6'h3F;
  localparam logic [5:0] BAD_FN = 6'h3F;
  localparam int unsigned RANDOM_ITEMS = 1300;

  class exec_outcome_board;
    exec_res_t   due[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function exec_res_t execute_instruction(logic [31:0] ins, logic [31:0] a, logic [31:0] b,
                                            logic [31:0] pc);
      exec_res_t   r;
      logic [5:0]  op;
      logic [5:0]  fn;
      logic [4:0]  rt;
      logic [4:0]  rd;
      logic [4:0]  sh;
      logic [31:0] simm;
      logic [31:0] nxt;
      logic        bad;
      r    = '0;
      bad  = 1'b0;
      op   = ins[31:26];
      fn   = ins[5:0];
      rt   = ins[20:16];
      rd   = ins[15:11];
      sh   = ins[10:6];
      simm = {{16{ins[15]}}, ins[15:0]};
      nxt  = pc + 32'd4;
      case (op)
        OP_SPECIAL: begin
          r.write_enable = 1'b1;
          r.dest_reg     = rd;
          case (fn)
            FN_ADDU: r.result = a + b;
            FN_SUBU: r.result = a - b;
            FN_AND:  r.result = a & b;
            FN_OR:   r.result = a | b;
            FN_NOR:  r.result = ~(a | b);
            FN_SLTU: r.result = {31'd0, a < b};
            FN_SLL:  r.result = b << sh;
            FN_SRL:  r.result = b >> sh;
            FN_JR: begin
              r.write_enable = 1'b0;
              r.dest_reg     = '0;
              r.redirect     = 1'b1;
              r.target       = a;
            end
            default: bad = 1'b1;
          endcase
        end
        OP_J, OP_JAL: begin
          r.redirect = 1'b1;
          r.target   = {nxt[31:28], ins[25:0], 2'b00};
          if (op == OP_JAL) begin
            r.write_enable = 1'b1;
            r.dest_reg     = LINK_REG;
            r.result       = nxt;
          end
        end
        OP_ADDIU, OP_ANDI, OP_ORI, OP_SLTIU, OP_LUI: begin
          r.write_enable = 1'b1;
          r.dest_reg     = rt;
          case (op)
            OP_ADDIU: r.result = a + simm;
            OP_ANDI:  r.result = a & {16'd0, ins[15:0]};
            OP_ORI:   r.result = a | {16'd0, ins[15:0]};
            OP_SLTIU: r.result = {31'd0, a < simm};
            default:  r.result = {ins[15:0], 16'd0};
          endcase
        end
        OP_BEQ, OP_BNE: begin
          if ((a == b) == (op == OP_BEQ)) begin
            r.redirect = 1'b1;
            r.target   = nxt + (simm << 2);
          end
        end
        OP_LW:   r.mem_kind = MEM_LW;
        OP_LB:   r.mem_kind = MEM_LB;
        OP_SW:   r.mem_kind = MEM_SW;
        OP_SB:   r.mem_kind = MEM_SB;
        default: bad = 1'b1;
      endcase
      if (r.mem_kind != MEM_NONE) begin
        r.mem_address = a + simm;
        r.result      = r.mem_address;
        if (r.mem_kind == MEM_LW || r.mem_kind == MEM_LB) begin
          r.write_enable = 1'b1;
          r.dest_reg     = rt;
        end
      end
      if (bad) begin
        r             = '0;
        r.unsupported = 1'b1;
      end
      return r;
    endfunction

    function void note_issue(logic [31:0] ins, logic [31:0] a, logic [31:0] b, logic [31:0] pc);
      due.push_back(execute_instruction(ins, a, b, pc));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %h, actual %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_outcome(exec_res_t got);
      exec_res_t want;
      if (due.size() == 0) begin
        $display("%0t: result with nothing outstanding, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = due.pop_front();
      compare_field("result", want.result, got.result);
      compare_field("write_enable", want.write_enable, got.write_enable);
      compare_field("dest_reg", want.dest_reg, got.dest_reg);
      compare_field("redirect", want.redirect, got.redirect);
      compare_field("target", want.target, got.target);
      compare_field("mem_kind", want.mem_kind, got.mem_kind);
      compare_field("mem_address", want.mem_address, got.mem_address);
      compare_field("unsupported", want.unsupported, got.unsupported);
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_instruction = '0;
  logic [31:0] in_rs_value = '0;
  logic [31:0] in_rt_value = '0;
  logic [31:0] in_pc = '0;
  logic        out_valid;
  logic [31:0] out_result;
  logic        out_write_enable;
  logic [4:0]  out_dest_reg;
  logic        out_redirect;
  logic [31:0] out_target;
  logic [2:0]  out_mem_kind;
  logic [31:0] out_mem_address;
  logic        out_unsupported;

  logic [5:0] alu_functs [0:8] = '{FN_ADDU, FN_SUBU, FN_AND, FN_OR, FN_NOR, FN_SLTU,
                                   FN_SLL, FN_SRL, FN_JR};
  logic [5:0] main_ops [0:12] = '{OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_ADDIU, OP_SLTIU, OP_ANDI,
                                  OP_ORI, OP_LUI, OP_LB, OP_LW, OP_SB, OP_SW};

  exec_outcome_board board;

  mips_subset_execute_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_instruction   (in_instruction),
    .in_rs_value      (in_rs_value),
    .in_rt_value      (in_rt_value),
    .in_pc            (in_pc),
    .out_valid        (out_valid),
    .out_result       (out_result),
    .out_write_enable (out_write_enable),
    .out_dest_reg     (out_dest_reg),
    .out_redirect     (out_redirect),
    .out_target       (out_target),
    .out_mem_kind     (out_mem_kind),
    .out_mem_address  (out_mem_address),
    .out_unsupported  (out_unsupported)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // transfers in both directions, sampled at the rising edge
  always @(posedge clk) begin
    exec_res_t got;
    if (rst_n) begin
      if (out_valid) begin
        got.result       = out_result;
        got.write_enable = out_write_enable;
        got.dest_reg     = out_dest_reg;
        got.redirect     = out_redirect;
        got.target       = out_target;
        got.mem_kind     = mem_kind_t'(out_mem_kind);
        got.mem_address  = out_mem_address;
        got.unsupported  = out_unsupported;
        board.check_outcome(got);
      end
      if (start && !busy)
        board.note_issue(in_instruction, in_rs_value, in_rt_value, in_pc);
    end
  end

  function automatic logic [31:0] rtype(logic [5:0] fn, logic [4:0] rd, logic [4:0] sh);
    return {OP_SPECIAL, 5'd31, 5'd31, rd, sh, fn};
  endfunction

  function automatic logic [31:0] itype(logic [5:0] op, logic [4:0] rt, logic [15:0] imm);
    return {op, 5'd1, rt, imm};
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic issue(logic [31:0] ins, logic [31:0] a, logic [31:0] b, logic [31:0] pc);
    @(negedge clk);
    start          <= 1'b1;
    in_instruction <= ins;
    in_rs_value    <= a;
    in_rt_value    <= b;
    in_pc          <= pc;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle(int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic issue_random();
    logic [31:0] ins;
    logic [31:0] a;
    logic [31:0] b;
    int unsigned sel;
    ins = $urandom;
    a   = pick_word();
    b   = pick_word();
    case ($urandom_range(0, 19))
      0, 1: ;
      2:    ins[31:26] = OP_SPECIAL;
      default: begin
        sel = $urandom_range(0, 21);
        if (sel < 9)
          ins = {OP_SPECIAL, ins[25:6], alu_functs[sel]};
        else
          ins[31:26] = main_ops[sel - 9];
        if ($urandom_range(0, 2) == 0)
          b = a;
      end
    endcase
    case ($urandom_range(0, 7))
      0:       ins[15:0] = 16'h0000;
      1:       ins[15:0] = 16'hFFFF;
      2:       ins[15:0] = 16'h8000;
      3:       ins[15:0] = 16'h7FFF;
      default: ;
    endcase
    issue(ins, a, b, pick_word());
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;
    board = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    issue(rtype(FN_ADDU, 5'd31, 5'd31), 32'hFFFF_FFFF, 32'h0000_0001, 32'h0);
    issue(rtype(FN_SUBU, 5'd1, 5'd0), 32'h0, 32'h1, 32'h0);
    issue(rtype(FN_AND, 5'd2, 5'd0), 32'hF0F0_FFFF, 32'hFFFF_0F0F, 32'h0);
    issue(rtype(FN_OR, 5'd3, 5'd0), 32'hF0F0_0000, 32'h0000_0F0F, 32'h0);
    issue(rtype(FN_NOR, 5'd4, 5'd0), 32'h0, 32'h0, 32'h0);
    issue(rtype(FN_SLTU, 5'd5, 5'd0), 32'h1, 32'h8000_0000, 32'h0);
    issue(rtype(FN_SLTU, 5'd6, 5'd0), 32'hFFFF_FFFF, 32'h1, 32'h0);
    issue(rtype(FN_SLL, 5'd7, 5'd31), 32'hFFFF_FFFF, 32'h1, 32'h0);
    issue(rtype(FN_SRL, 5'd8, 5'd31), 32'h0, 32'h8000_0000, 32'h0);
    issue(rtype(FN_JR, 5'd9, 5'd0), 32'hFFFF_FFFC, 32'h0, 32'h0);
    // destination r0 still reports a write
    issue(itype(OP_ADDIU, 5'd0, 16'h8000), 32'h0, 32'h0, 32'h0);
    issue(itype(OP_ANDI, 5'd10, 16'hFFFF), 32'hFFFF_FFFF, 32'h0, 32'h0);
    issue(itype(OP_ORI, 5'd11, 16'h8000), 32'h0, 32'h0, 32'h0);
    issue(itype(OP_SLTIU, 5'd12, 16'hFFFF), 32'h5, 32'h0, 32'h0);
    issue(itype(OP_LUI, 5'd13, 16'hFFFF), 32'h0, 32'h0, 32'h0);
    issue(itype(OP_BEQ, 5'd0, 16'h8000), 32'h1234_5678, 32'h1234_5678, 32'h0);
    issue(itype(OP_BEQ, 5'd0, 16'h0004), 32'h1, 32'h0, 32'h100);
    issue(itype(OP_BNE, 5'd0, 16'h7FFF), 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFF0);
    issue(itype(OP_BNE, 5'd0, 16'h0004), 32'h7, 32'h7, 32'h100);
    issue({OP_J, 26'h3FF_FFFF}, 32'h0, 32'h0, 32'hFFFF_FFFC);
    issue({OP_JAL, 26'h000_0000}, 32'h0, 32'h0, 32'h7FFF_FFFC);
    issue(itype(OP_LW, 5'd14, 16'h0001), 32'hFFFF_FFFF, 32'h0, 32'h0);
    issue(itype(OP_LB, 5'd15, 16'h8000), 32'h0000_0010, 32'h0, 32'h0);
    issue(itype(OP_SW, 5'd31, 16'h7FFF), 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);
    issue(itype(OP_SB, 5'd16, 16'hFFFF), 32'h0, 32'hFFFF_FFFF, 32'h0);
    issue({BAD_OP, 26'h3FF_FFFF}, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue(rtype(BAD_FN, 5'd17, 5'd3), 32'h1, 32'h2, 32'h0);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        issue_random();
        sent++;
      end
      idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
    end
    idle(1);

    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("tb_mips_subset_execute_unit: clean");
    else
      $display("tb_mips_subset_execute_unit: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_mips_subset_execute_unit: errors");
    $finish;
  end

endmodule
